@@ design/assert_macros.svh @@
// Shared assertion macros for the register file ALU.
// Every macro samples on clk and is quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRIF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define CRIF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/crif_pkg.sv @@
package crif_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W   = 5;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_REGREG = 2'd2;
  localparam logic [1:0] KIND_REGIMM = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_OPER,
    S_EXEC,
    S_DIV,
    S_FINISH
  } crif_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic rd_first;
    logic rd_second;
    logic latch_a;
    logic latch_b;
    logic exec;
    logic div_step;
    logic finish;
  } crif_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_go;
    logic div_done;
  } crif_sts_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    m = '1;
    case (size)
      SIZE_BYTE: m = DATA_W'(32'h0000_00FF);
      SIZE_HALF: m = DATA_W'(32'h0000_FFFF);
      default:   m = '1;
    endcase
    return m;
  endfunction

  // Size code three reports as a word.
  function automatic logic [1:0] size_clip(input logic [1:0] size);
    logic [1:0] s;
    s = size;
    if (size == SIZE_BYTE || size == SIZE_HALF) begin
      s = size;
    end else begin
      s = SIZE_WORD;
    end
    return s;
  endfunction

endpackage

@@ design/crif_ram.sv @@
module crif_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/crif_ctrl.sv @@
`include "assert_macros.svh"

module crif_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               res_valid,
  input  logic               res_stall,
  input  crif_pkg::crif_sts_t sts,
  output crif_pkg::crif_cmd_t cmd
);

  crif_pkg::crif_state_t state;
  crif_pkg::crif_state_t state_next;
  logic                  out_free;

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crif_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crif_pkg::S_IDLE: begin
        if (req_valid) state_next = crif_pkg::S_READ_A;
      end
      crif_pkg::S_READ_A: state_next = crif_pkg::S_READ_B;
      crif_pkg::S_READ_B: state_next = crif_pkg::S_OPER;
      crif_pkg::S_OPER:   state_next = crif_pkg::S_EXEC;
      crif_pkg::S_EXEC: begin
        state_next = sts.div_go ? crif_pkg::S_DIV : crif_pkg::S_FINISH;
      end
      crif_pkg::S_DIV: begin
        if (sts.div_done) state_next = crif_pkg::S_FINISH;
      end
      crif_pkg::S_FINISH: begin
        if (out_free) state_next = crif_pkg::S_IDLE;
      end
      default: state_next = crif_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      crif_pkg::S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      crif_pkg::S_READ_A: cmd.rd_first = 1'b1;
      crif_pkg::S_READ_B: begin
        cmd.latch_a   = 1'b1;
        cmd.rd_second = 1'b1;
      end
      crif_pkg::S_OPER:   cmd.latch_b  = 1'b1;
      crif_pkg::S_EXEC:   cmd.exec     = 1'b1;
      crif_pkg::S_DIV:    cmd.div_step = 1'b1;
      crif_pkg::S_FINISH: cmd.finish   = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  `CRIF_ASSERT_NEXT(a_accept_reads, req_valid && !req_stall, state == crif_pkg::S_READ_A)
  `CRIF_ASSERT_IMPLY(a_finish_free, cmd.finish, !res_valid || !res_stall)
  `CRIF_ASSERT_NEXT(a_div_ends, cmd.div_step && sts.div_done, state == crif_pkg::S_FINISH)
  `CRIF_ASSERT_NEXT(a_finish_shows, cmd.finish, res_valid && state == crif_pkg::S_IDLE)

endmodule

@@ design/crif_dp.sv @@
module crif_dp #(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  crif_pkg::crif_cmd_t        cmd,
  output crif_pkg::crif_sts_t        sts,
  input  logic                       cfg_write_enable,
  input  logic                       cfg_write_data,
  input  logic [1:0]                 kind,
  input  logic [1:0]                 op,
  input  logic [1:0]                 access_size,
  input  logic [crif_pkg::IDX_W-1:0] first_index,
  input  logic [crif_pkg::IDX_W-1:0] second_index,
  input  logic [31:0]                operand_value,
  input  logic [31:0]                target_address,
  output logic                       store_valid,
  output logic [31:0]                store_address,
  output logic [31:0]                store_data,
  output logic [1:0]                 store_size,
  output logic [31:0]                written_value,
  output logic                       divide_by_zero
);

  localparam int unsigned AW = $clog2(REGISTER_COUNT);
  localparam int unsigned EW = crif_pkg::IDX_W + AW;

  function automatic logic in_range(input logic [crif_pkg::IDX_W-1:0] idx);
    logic [EW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext < EW'(REGISTER_COUNT);
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [crif_pkg::IDX_W-1:0] idx);
    logic [EW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  logic [1:0]                 kind_q;
  logic [1:0]                 op_q;
  logic [1:0]                 size_q;
  logic [crif_pkg::IDX_W-1:0] first_q;
  logic [crif_pkg::IDX_W-1:0] second_q;
  logic [31:0]                operand_q;
  logic [31:0]                addr_q;
  logic [31:0]                a;
  logic [31:0]                b;
  logic [31:0]                res_val;
  logic                       dz_q;
  logic [31:0]                quo;
  logic [31:0]                rem;
  logic [crif_pkg::CNT_W-1:0] cnt;
  logic [REGISTER_COUNT-1:0]  vld;
  logic                       mwe;
  logic                       rd_ok;
  logic [31:0]                ram_q;
  logic [31:0]                word;
  logic                       arith;
  logic                       is_store;
  logic                       store_on;
  logic                       bank_we;
  logic [AW-1:0]              rd_addr;
  logic [32:0]                shifted;
  logic [32:0]                diff;
  logic [31:0]                quo_next;
  logic [31:0]                rem_next;

  assign arith    = (kind_q == crif_pkg::KIND_REGREG) || (kind_q == crif_pkg::KIND_REGIMM);
  assign is_store = kind_q == crif_pkg::KIND_STORE;
  assign store_on = is_store && mwe;
  assign word     = rd_ok ? ram_q : '0;
  assign rd_addr  = cmd.rd_first ? bank_addr(first_q) : bank_addr(second_q);
  assign bank_we  = cmd.finish && !is_store && in_range(first_q);

  assign sts.div_go   = arith && (op_q == crif_pkg::OP_DIV) && (b != '0);
  assign sts.div_done = cnt == '0;

  crif_ram #(
    .WIDTH (crif_pkg::DATA_W),
    .DEPTH (REGISTER_COUNT)
  ) u_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_addr(first_q)),
    .wdata (res_val),
    .re    (cmd.rd_first || cmd.rd_second),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Restoring divider, one quotient bit per step.
  assign shifted  = {rem, quo[31]};
  assign diff     = shifted - {1'b0, b};
  assign rem_next = diff[32] ? shifted[31:0] : diff[31:0];
  assign quo_next = {quo[30:0], !diff[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      mwe <= 1'b0;
    end else begin
      if (cfg_write_enable) mwe <= cfg_write_data;
      if (bank_we) vld[bank_addr(first_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind;
      op_q      <= op;
      size_q    <= access_size;
      first_q   <= first_index;
      second_q  <= second_index;
      operand_q <= operand_value;
      addr_q    <= target_address;
    end
    if (cmd.rd_first) rd_ok <= in_range(first_q) && vld[bank_addr(first_q)];
    if (cmd.rd_second) rd_ok <= in_range(second_q) && vld[bank_addr(second_q)];
    if (cmd.latch_a) a <= word;
    if (cmd.latch_b) b <= (kind_q == crif_pkg::KIND_REGREG) ? word : operand_q;
    if (cmd.exec) begin
      dz_q <= arith && (op_q == crif_pkg::OP_DIV) && (b == '0);
      quo  <= a;
      rem  <= '0;
      cnt  <= crif_pkg::CNT_W'(crif_pkg::DIV_STEPS - 1);
      if (kind_q == crif_pkg::KIND_LOAD) begin
        res_val <= operand_q & crif_pkg::size_mask(size_q);
      end else if (is_store) begin
        res_val <= '0;
      end else begin
        case (op_q)
          crif_pkg::OP_ADD: res_val <= a + b;
          crif_pkg::OP_SUB: res_val <= a - b;
          crif_pkg::OP_MUL: res_val <= a * b;
          default:          res_val <= '1;
        endcase
      end
    end
    if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt - 1'b1;
      if (sts.div_done) res_val <= quo_next;
    end
    if (cmd.finish) begin
      store_valid    <= store_on;
      store_address  <= store_on ? addr_q : '0;
      store_data     <= store_on ? (a & crif_pkg::size_mask(size_q)) : '0;
      store_size     <= store_on ? crif_pkg::size_clip(size_q) : crif_pkg::SIZE_BYTE;
      written_value  <= res_val;
      divide_by_zero <= dz_q;
    end
  end

endmodule

@@ design/code_register_file_integer_alu.sv @@
// Integer register file with a small ALU for code register instructions.
// Request channel: req_valid / req_stall carry kind, op, access_size,
// first_index, second_index, operand_value and target_address. A request
// is taken at a clock edge with req_valid high and req_stall low.
// Result channel: res_valid / res_stall carry one result per request
// (store_valid, store_address, store_data, store_size, written_value,
// divide_by_zero); it is taken when res_valid is high and res_stall low.
// Sequence: an accepted request steps through READ_A, READ_B, OPER, EXEC
// and FINISH; a divide with a nonzero divisor adds S_DIV after EXEC,
// where the restoring divider forms one quotient bit per cycle.
// One request is in flight at a time. The bank RAM has one read port, so
// the two reads go in separate states, READ_A and READ_B.
// The output register parts the channels: a new request is taken while a
// result still waits; a request that is done holds in its last step until
// the receiver frees the output register, and a stalled result holds.
// Reset (rst, synchronous) empties the pipeline, clears the bank through
// per-entry valid bits (no clearing pass) and disables memory writes.
// cfg_write_enable / cfg_write_data set the memory-write enable; write it
// only while no request is in flight.
module code_register_file_integer_alu #(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [1:0]  op,
  input  logic [1:0]  access_size,
  input  logic [3:0]  first_index,
  input  logic [3:0]  second_index,
  input  logic [31:0] operand_value,
  input  logic [31:0] target_address,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        store_valid,
  output logic [31:0] store_address,
  output logic [31:0] store_data,
  output logic [1:0]  store_size,
  output logic [31:0] written_value,
  output logic        divide_by_zero
);

  crif_pkg::crif_cmd_t cmd;
  crif_pkg::crif_sts_t sts;

  // Sequence the request: read, operate, divide, deliver.
  crif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the bank, ALU, divider and result register.
  crif_dp #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .kind             (kind),
    .op               (op),
    .access_size      (access_size),
    .first_index      (first_index),
    .second_index     (second_index),
    .operand_value    (operand_value),
    .target_address   (target_address),
    .store_valid      (store_valid),
    .store_address    (store_address),
    .store_data       (store_data),
    .store_size       (store_size),
    .written_value    (written_value),
    .divide_by_zero   (divide_by_zero)
  );

endmodule

@@ verif/tb_code_register_file_integer_alu.sv @@
`timescale 1ns / 100ps

module tb_code_register_file_integer_alu;

  // Access size code three; the block treats it as a word.
  localparam logic [1:0] SIZE_ALIAS_WORD = 2'd3;

  localparam int unsigned RANDOM_PHASES    = 5;
  localparam int unsigned PHASE_REQUESTS   = 190;
  localparam int unsigned HOLDOFF_AT       = 500;
  localparam int unsigned HOLDOFF_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [1:0]  access_size;
    logic [3:0]  first_index;
    logic [3:0]  second_index;
    logic [31:0] operand_value;
    logic [31:0] target_address;
  } alu_request_t;

  typedef struct packed {
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_data;
    logic [1:0]  store_size;
    logic [31:0] written_value;
    logic        divide_by_zero;
  } alu_result_t;

  // One row of the directed table: either a config write or a request,
  // optionally with its result typed in by hand.
  typedef struct {
    bit           is_cfg;
    bit           cfg_value;
    alu_request_t req;
    bit           has_typed;
    alu_result_t  typed;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_enable;
  logic        cfg_write_data;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  kind;
  logic [1:0]  op;
  logic [1:0]  access_size;
  logic [3:0]  first_index;
  logic [3:0]  second_index;
  logic [31:0] operand_value;
  logic [31:0] target_address;
  logic        res_valid;
  logic        res_stall;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_data;
  logic [1:0]  store_size;
  logic [31:0] written_value;
  logic        divide_by_zero;

  // Hand-typed expectation that travels with the request on the wire.
  logic        row_typed;
  alu_result_t row_expect;

  // Shadow of the block: register bank and the memory-write enable.
  logic [31:0] shadow_bank [16];
  logic        shadow_writes_enabled;

  alu_result_t   pending_results [$];
  directed_row_t directed_rows [$];

  int unsigned mismatch_count;
  int unsigned requests_accepted;
  int unsigned results_checked;
  int unsigned load_count, store_count, stores_emitted;
  int unsigned alu_count, divide_count, zero_divide_count;
  int unsigned input_stall_cycles;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned cycle_count;
  bit          holdoff_done;

  bit          phase_enable [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int unsigned phase_gap    [RANDOM_PHASES] = '{6, 0, 12, 3, 8};

  code_register_file_integer_alu #(
    .REGISTER_COUNT(16)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .kind            (kind),
    .op              (op),
    .access_size     (access_size),
    .first_index     (first_index),
    .second_index    (second_index),
    .operand_value   (operand_value),
    .target_address  (target_address),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .store_valid     (store_valid),
    .store_address   (store_address),
    .store_data      (store_data),
    .store_size      (store_size),
    .written_value   (written_value),
    .divide_by_zero  (divide_by_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mask a value down to its access size; sizes two and three are words.
  function automatic logic [31:0] width_mask(input logic [1:0] size);
    logic [31:0] m;
    case (size)
      crif_pkg::SIZE_BYTE: m = 32'h0000_00FF;
      crif_pkg::SIZE_HALF: m = 32'h0000_FFFF;
      default:             m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Compute the result of one request and advance the shadow bank.
  function automatic alu_result_t predict_outcome(input alu_request_t r);
    alu_result_t res;
    logic [31:0] lhs, rhs, value;
    logic        zero_div;
    res = '0;
    zero_div = 1'b0;
    case (r.kind)
      crif_pkg::KIND_LOAD: begin
        value = r.operand_value & width_mask(r.access_size);
        shadow_bank[r.first_index] = value;
        res.written_value = value;
      end
      crif_pkg::KIND_STORE: begin
        // A disabled store leaves every field at zero.
        if (shadow_writes_enabled) begin
          res.store_valid   = 1'b1;
          res.store_address = r.target_address;
          res.store_data    = shadow_bank[r.first_index] & width_mask(r.access_size);
          res.store_size    = (r.access_size == SIZE_ALIAS_WORD) ? crif_pkg::SIZE_WORD
                                                                 : r.access_size;
        end
      end
      default: begin
        lhs = shadow_bank[r.first_index];
        rhs = (r.kind == crif_pkg::KIND_REGREG) ? shadow_bank[r.second_index]
                                                : r.operand_value;
        case (r.op)
          crif_pkg::OP_ADD: value = lhs + rhs;
          crif_pkg::OP_SUB: value = lhs - rhs;
          crif_pkg::OP_MUL: value = lhs * rhs;
          default: begin
            // A zero divisor saturates the quotient and raises the flag.
            if (rhs == 32'd0) begin
              value    = 32'hFFFF_FFFF;
              zero_div = 1'b1;
            end else begin
              value = lhs / rhs;
            end
          end
        endcase
        shadow_bank[r.first_index] = value;
        res.written_value  = value;
        res.divide_by_zero = zero_div;
      end
    endcase
    return res;
  endfunction

  function automatic alu_request_t instr(input logic [1:0] k, input logic [1:0] o,
                                         input logic [1:0] s, input logic [3:0] fi,
                                         input logic [3:0] si, input logic [31:0] val,
                                         input logic [31:0] addr);
    alu_request_t r;
    r = '{kind: k, op: o, access_size: s, first_index: fi, second_index: si,
          operand_value: val, target_address: addr};
    return r;
  endfunction

  function automatic alu_result_t outcome(input logic sv, input logic [31:0] sa,
                                          input logic [31:0] sd, input logic [1:0] ss,
                                          input logic [31:0] wv, input logic dz);
    alu_result_t res;
    res = '{store_valid: sv, store_address: sa, store_data: sd, store_size: ss,
            written_value: wv, divide_by_zero: dz};
    return res;
  endfunction

  // Bias operands toward values that matter for the ALU: small divisors,
  // zero, one and the word extremes, plus plenty of full-width noise.
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = $urandom_range(0, 15);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(0, 32'h0000_FFFF);
    endcase
    return v;
  endfunction

  function automatic alu_request_t random_request();
    alu_request_t r;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.kind = crif_pkg::KIND_LOAD;
    end else if (pick < 45) begin
      r.kind = crif_pkg::KIND_STORE;
    end else if (pick < 70) begin
      r.kind = crif_pkg::KIND_REGREG;
    end else begin
      r.kind = crif_pkg::KIND_REGIMM;
    end
    r.op = 2'($urandom_range(0, 3));
    // Size code three shows up now and then.
    r.access_size = ($urandom_range(0, 9) == 0) ? SIZE_ALIAS_WORD
                                                 : 2'($urandom_range(0, 2));
    r.first_index    = 4'($urandom_range(0, 15));
    r.second_index   = 4'($urandom_range(0, 15));
    r.operand_value  = random_operand();
    r.target_address = $urandom();
    return r;
  endfunction

  task automatic add_row(input bit is_cfg, input bit cfg_value, input alu_request_t r,
                         input bit has_typed, input alu_result_t t);
    directed_row_t row;
    row.is_cfg    = is_cfg;
    row.cfg_value = cfg_value;
    row.req       = r;
    row.has_typed = has_typed;
    row.typed     = t;
    directed_rows.push_back(row);
  endtask

  // Offer one request and hold it until the block takes it. Valid stays
  // high across a burst; between bursts drop it for a random gap.
  task automatic offer(input alu_request_t r, input bit has_typed, input alu_result_t t);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    kind           <= r.kind;
    op             <= r.op;
    access_size    <= r.access_size;
    first_index    <= r.first_index;
    second_index   <= r.second_index;
    operand_value  <= r.operand_value;
    target_address <= r.target_address;
    row_typed      <= has_typed;
    row_expect     <= t;
    req_valid      <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every request in flight has returned.
  task automatic drain_block();
    @(negedge clk);
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the memory-write enable; only done with the block idle.
  task automatic set_store_enable(input bit value);
    drain_block();
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Scoreboard: check results against the oldest expectation first, then
  // record any request accepted at this edge. Results never leave in the
  // edge that accepts their request, so the order here is harmless.
  always @(posedge clk) begin : scoreboard
    alu_result_t  want, predicted;
    alu_request_t taken;
    if (rst) begin
      for (int i = 0; i < 16; i++) shadow_bank[i] = 32'd0;
      shadow_writes_enabled = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, written_value %h",
                   $time, written_value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("store_valid", 32'(want.store_valid), 32'(store_valid));
          check_field("store_address", want.store_address, store_address);
          check_field("store_data", want.store_data, store_data);
          check_field("store_size", 32'(want.store_size), 32'(store_size));
          check_field("written_value", want.written_value, written_value);
          check_field("divide_by_zero", 32'(want.divide_by_zero), 32'(divide_by_zero));
          results_checked++;
        end
      end
      if (cfg_write_enable) shadow_writes_enabled = cfg_write_data;
      if (req_valid && req_stall) input_stall_cycles++;
      if (req_valid && !req_stall) begin
        taken = '{kind: kind, op: op, access_size: access_size,
                  first_index: first_index, second_index: second_index,
                  operand_value: operand_value, target_address: target_address};
        predicted = predict_outcome(taken);
        // A hand-typed row wins over the shadow; the shadow still advances.
        pending_results.push_back(row_typed ? row_expect : predicted);
        requests_accepted++;
        case (taken.kind)
          crif_pkg::KIND_LOAD:  load_count++;
          crif_pkg::KIND_STORE: begin
            store_count++;
            if (predicted.store_valid) stores_emitted++;
          end
          default: begin
            alu_count++;
            if (taken.op == crif_pkg::OP_DIV) divide_count++;
            if (predicted.divide_by_zero) zero_divide_count++;
          end
        endcase
      end
    end
  end

  // Receiver: stall in segments of random length and density, including
  // segments with no stall at all. Once, mid-run, hold off for a long
  // stretch so the block backs up and stalls its input.
  initial begin : result_sink
    int unsigned seg_len, stall_pct;
    res_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      seg_len = $urandom_range(8, 64);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2:    stall_pct = 30;
        3:    stall_pct = 60;
        default: stall_pct = 85;
      endcase
      repeat (seg_len) begin
        @(negedge clk);
        if (!holdoff_done && requests_accepted >= HOLDOFF_AT) begin
          holdoff_done = 1'b1;
          res_stall <= 1'b1;
          for (int c = 1; c < HOLDOFF_CYCLES; c++) @(negedge clk);
        end else begin
          res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  // Watchdog: end the run if it overstays the cycle budget.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    // Hold every input at a known value from time zero.
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data   = 1'b0;
    req_valid        = 1'b0;
    kind             = crif_pkg::KIND_LOAD;
    op               = crif_pkg::OP_ADD;
    access_size      = crif_pkg::SIZE_BYTE;
    first_index      = 4'd0;
    second_index     = 4'd0;
    operand_value    = 32'd0;
    target_address   = 32'd0;
    row_typed        = 1'b0;
    row_expect       = '0;
    burst_left       = 0;
    gap_max          = 3;

    // Directed table. Stores start out disabled after reset.
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF),
            1, outcome(0, 0, 0, 0, 0, 0));
    add_row(0, 0, instr(crif_pkg::KIND_LOAD, crif_pkg::OP_ADD, crif_pkg::SIZE_BYTE,
                        4'd1, 4'd0, 32'hFFFF_FFFF, 32'd0),
            1, outcome(0, 0, 0, 0, 32'h0000_00FF, 0));
    add_row(0, 0, instr(crif_pkg::KIND_LOAD, crif_pkg::OP_SUB, crif_pkg::SIZE_HALF,
                        4'd2, 4'd0, 32'hFFFF_FFFF, 32'd0),
            1, outcome(0, 0, 0, 0, 32'h0000_FFFF, 0));
    add_row(0, 0, instr(crif_pkg::KIND_LOAD, crif_pkg::OP_MUL, crif_pkg::SIZE_WORD,
                        4'd3, 4'd0, 32'hFFFF_FFFF, 32'd0),
            1, outcome(0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    add_row(0, 0, instr(crif_pkg::KIND_LOAD, crif_pkg::OP_DIV, SIZE_ALIAS_WORD,
                        4'd4, 4'd15, 32'h1234_5678, 32'hFFFF_FFFF),
            1, outcome(0, 0, 0, 0, 32'h1234_5678, 0));
    add_row(0, 0, instr(crif_pkg::KIND_LOAD, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd15, 4'd0, 32'h8000_0001, 32'd0),
            1, outcome(0, 0, 0, 0, 32'h8000_0001, 0));
    add_row(1, 1, '0, 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF),
            1, outcome(1, 32'hFFFF_FFFF, 32'd0, crif_pkg::SIZE_WORD, 0, 0));
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, crif_pkg::SIZE_BYTE,
                        4'd3, 4'd0, 32'd0, 32'd0),
            1, outcome(1, 32'd0, 32'h0000_00FF, crif_pkg::SIZE_BYTE, 0, 0));
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, crif_pkg::SIZE_HALF,
                        4'd3, 4'd0, 32'd0, 32'hA5A5_A5A5),
            1, outcome(1, 32'hA5A5_A5A5, 32'h0000_FFFF, crif_pkg::SIZE_HALF, 0, 0));
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, SIZE_ALIAS_WORD,
                        4'd4, 4'd0, 32'd0, 32'h0000_1000),
            1, outcome(1, 32'h0000_1000, 32'h1234_5678, crif_pkg::SIZE_WORD, 0, 0));
    // Wrap both ways at the word boundary.
    add_row(0, 0, instr(crif_pkg::KIND_REGIMM, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd3, 4'd0, 32'd1, 32'd0),
            1, outcome(0, 0, 0, 0, 32'd0, 0));
    add_row(0, 0, instr(crif_pkg::KIND_REGIMM, crif_pkg::OP_SUB, crif_pkg::SIZE_WORD,
                        4'd0, 4'd0, 32'd1, 32'd0),
            1, outcome(0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    add_row(0, 0, instr(crif_pkg::KIND_REGIMM, crif_pkg::OP_MUL, crif_pkg::SIZE_WORD,
                        4'd2, 4'd0, 32'h0000_FFFF, 32'd0),
            0, '0);
    // Divide by zero, immediate and register forms.
    add_row(0, 0, instr(crif_pkg::KIND_REGIMM, crif_pkg::OP_DIV, crif_pkg::SIZE_WORD,
                        4'd1, 4'd0, 32'd0, 32'd0),
            1, outcome(0, 0, 0, 0, 32'hFFFF_FFFF, 1));
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_DIV, crif_pkg::SIZE_WORD,
                        4'd5, 4'd6, 32'd0, 32'd0),
            1, outcome(0, 0, 0, 0, 32'hFFFF_FFFF, 1));
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd2, 4'd1, 32'd0, 32'd0), 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_SUB, crif_pkg::SIZE_WORD,
                        4'd1, 4'd2, 32'd0, 32'd0), 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_MUL, crif_pkg::SIZE_WORD,
                        4'd15, 4'd15, 32'd0, 32'd0), 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_DIV, crif_pkg::SIZE_WORD,
                        4'd4, 4'd2, 32'd0, 32'd0), 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_REGIMM, crif_pkg::OP_DIV, crif_pkg::SIZE_WORD,
                        4'd0, 4'd0, 32'hFFFF_FFFF, 32'd0), 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_REGREG, crif_pkg::OP_SUB, crif_pkg::SIZE_WORD,
                        4'd15, 4'd15, 32'd0, 32'd0), 0, '0);
    add_row(1, 0, '0, 0, '0);
    add_row(0, 0, instr(crif_pkg::KIND_STORE, crif_pkg::OP_ADD, crif_pkg::SIZE_WORD,
                        4'd4, 4'd0, 32'd0, 32'h0000_2000),
            1, outcome(0, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        set_store_enable(directed_rows[i].cfg_value);
      end else begin
        offer(directed_rows[i].req, directed_rows[i].has_typed, directed_rows[i].typed);
      end
    end

    // Random phases, each with its own store setting and sender gap width;
    // one phase runs the sender with no gaps at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_store_enable(phase_enable[p]);
      gap_max = phase_gap[p];
      repeat (PHASE_REQUESTS) offer(random_request(), 1'b0, '0);
    end

    // Drain, then give the divider time to show any stray result.
    drain_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      mismatch_count++;
    end

    $display("Covered %0d requests: %0d loads, %0d stores (%0d emitted), %0d ALU ops",
             requests_accepted, load_count, store_count, stores_emitted, alu_count);
    $display("Divides %0d (%0d by zero), %0d results checked, input stalled %0d cycles",
             divide_count, zero_divide_count, results_checked, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
